@@ hw/rtl/ppl_pkg.sv @@
// Package: shared constants and types for the particle pool lifetime update block.
`default_nettype none
package ppl_pkg;
    localparam int CAPACITY = 256;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = SLOT_W + 1;
    localparam int DT_W = 24;
    localparam int AGE_W = 17;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SPAWN = 2'd1,
        MODE_KILL  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_OOR  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ORDER,
        S_SPAWN_WR,
        S_READ_DATA,
        S_READ_OUT,
        S_TK_NEXT,
        S_TK_ORDER,
        S_TK_SLOT,
        S_TK_AGE,
        S_TK_AXIS,
        S_TK_AXWR,
        S_TK_KILL_LAST,
        S_TK_KILL_WR,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

@@ hw/rtl/ppl_step_unit.sv @@
// Shared step unit: registered signed rate * dt, then floor shift and add, saturating when sat is set.
`default_nettype none
module ppl_step_unit
    import ppl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic signed [31:0]     rate,
    input  wire logic [DT_W-1:0]        dt,
    input  wire logic signed [31:0]     base,
    input  wire logic                   sat,
    output logic signed [31:0]          result
);
    logic signed [56:0] prod_reg;
    logic signed [40:0] step;
    logic signed [41:0] sum;

    always_ff @(posedge clk)
    begin
        prod_reg <= 57'(rate * $signed({1'b0, dt}));
    end

    always_comb
    begin
        step = 41'(prod_reg >>> 16);
        sum = 42'(base) + 42'(step);
        if (!sat)
            result = sum[31:0];
        else if (sum > 42'sd2147483647)
            result = 32'sh7fffffff;
        else if (sum < -42'sd2147483648)
            result = 32'sh80000000;
        else
            result = sum[31:0];
    end
endmodule
`default_nettype wire

@@ hw/rtl/particle_pool_lifetime_update.sv @@
// Top level: particle pool with swap-remove lifetime update, one shared step unit.
// Kill-all, full spawn and out-of-range read go straight to the result; a spawn reads
// the slot order first, a read the order and then the slot data. The next item is
// taken after the result has left. A tick walks live slots, skipping frozen particles,
// swap-removing dead ones and stepping x, y, z and rotation on the shared multiplier.
// One item at a time; s_tready is high only in idle. Reset (rst_n, async low)
// clears the count and control; slot order is restored by a pass over every slot.
`default_nettype none
module particle_pool_lifetime_update
    import ppl_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // mode, delta_time, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_rate,
    // inv_life, flags, read_index; zero-filled to 288 bits
    input  wire logic [287:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // live_count, status, slot, out_pos_x/y/z, out_rotation, out_age, out_flags;
    // zero-filled to 168 bits
    output logic [167:0]       m_tdata
);
    logic [1:0]  in_mode;
    logic [7:0]  in_idx;
    assign in_mode  = s_tdata[1:0];
    assign in_idx   = s_tdata[285:278];

    logic [SLOT_W-1:0] order_mem [CAPACITY];
    logic [31:0] pos_mem [3][CAPACITY];
    logic [31:0] vel_mem [3][CAPACITY];
    logic [31:0] spin_mem [CAPACITY];
    logic [31:0] rate_mem [CAPACITY];
    logic [AGE_W-1:0] age_mem [CAPACITY];
    logic [DT_W-1:0] il_mem [CAPACITY];
    logic [3:0] flag_mem [CAPACITY];

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic clr_reg, clr_next;
    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;
    logic [1:0] axis_reg, axis_next;
    logic [287:0] in_reg;
    logic [167:0] out_reg;
    logic out_load;
    logic [1:0] out_status;
    logic [SLOT_W-1:0] out_slot;
    logic out_data;

    // memory control
    logic [SLOT_W-1:0] ord_raddr;
    logic [SLOT_W-1:0] ord_rdata_reg, slot_reg;
    logic ord_we;
    logic [SLOT_W-1:0] ord_waddr, ord_wdata;
    logic [31:0] px_q, py_q, pz_q, spin_q;
    logic [31:0] vx_q, vy_q, vz_q, sr_q;
    logic [AGE_W-1:0] age_q;
    logic [DT_W-1:0] il_q;
    logic [3:0] flag_q;
    logic [31:0] rate_q, base_q;
    logic [47:0] age_prod_reg;
    logic [32:0] age_sum;
    logic spawn_we, axis_we, age_we;
    logic [31:0] step_res;

    always_comb
    begin
        case (axis_reg)
            2'd0:
            begin
                base_q = px_q;
                rate_q = vx_q;
            end
            2'd1:
            begin
                base_q = py_q;
                rate_q = vy_q;
            end
            2'd2:
            begin
                base_q = pz_q;
                rate_q = vz_q;
            end
            default:
            begin
                base_q = spin_q;
                rate_q = sr_q;
            end
        endcase
    end

    ppl_step_unit u_step (
        .clk    (clk),
        .rate   ($signed(rate_q)),
        .dt     (in_reg[25:2]),
        .base   ($signed(base_q)),
        .sat    (axis_reg != 2'd3),
        .result (step_res)
    );

    always_ff @(posedge clk)
    begin
        ord_rdata_reg <= order_mem[ord_raddr];
        if (ord_we)
            order_mem[ord_waddr] <= ord_wdata;
        px_q   <= pos_mem[0][slot_reg];
        py_q   <= pos_mem[1][slot_reg];
        pz_q   <= pos_mem[2][slot_reg];
        vx_q   <= vel_mem[0][slot_reg];
        vy_q   <= vel_mem[1][slot_reg];
        vz_q   <= vel_mem[2][slot_reg];
        spin_q <= spin_mem[slot_reg];
        sr_q   <= rate_mem[slot_reg];
        age_q  <= age_mem[slot_reg];
        il_q   <= il_mem[slot_reg];
        flag_q <= flag_mem[slot_reg];
        age_prod_reg <= 48'(in_reg[25:2]) * 48'(il_q);
        if (spawn_we)
        begin
            pos_mem[0][slot_reg] <= in_reg[57:26];
            pos_mem[1][slot_reg] <= in_reg[89:58];
            pos_mem[2][slot_reg] <= in_reg[121:90];
            vel_mem[0][slot_reg] <= in_reg[153:122];
            vel_mem[1][slot_reg] <= in_reg[185:154];
            vel_mem[2][slot_reg] <= in_reg[217:186];
            rate_mem[slot_reg]   <= in_reg[249:218];
            il_mem[slot_reg]     <= in_reg[273:250];
            flag_mem[slot_reg]   <= in_reg[277:274];
            spin_mem[slot_reg]   <= '0;
            age_mem[slot_reg]    <= '0;
        end
        if (age_we)
        begin
            age_mem[slot_reg]  <= age_sum[AGE_W-1:0];
            flag_mem[slot_reg] <= {1'b0, flag_q[2:0]};
        end
        if (axis_we)
        begin
            if (axis_reg == 2'd3)
                spin_mem[slot_reg] <= step_res;
            else
                pos_mem[axis_reg][slot_reg] <= step_res;
        end
    end

    assign age_sum = 33'(age_q) + 33'(age_prod_reg[47:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            axis_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            clr_reg     <= clr_next;
            clr_idx_reg <= clr_idx_next;
            axis_reg    <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= s_tdata;
        if (state_reg == S_TK_ORDER || state_reg == S_RD_ORDER)
            slot_reg <= ord_rdata_reg;
        if (out_load)
            out_reg <= {1'b0,
                        out_data ? flag_q : 4'd0,
                        out_data ? age_q[15:0] : 16'd0,
                        out_data ? spin_q : 32'd0,
                        out_data ? pz_q : 32'd0,
                        out_data ? py_q : 32'd0,
                        out_data ? px_q : 32'd0,
                        out_slot, out_status, cnt_next};
    end

    logic m_valid_reg, m_valid_next;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign s_tready = (state_reg == S_IDLE) && !clr_reg && !m_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        clr_next     = clr_reg;
        clr_idx_next = clr_idx_reg;
        axis_next    = axis_reg;
        ord_raddr    = '0;
        ord_we       = 1'b0;
        ord_waddr    = clr_idx_reg;
        ord_wdata    = clr_idx_reg;
        spawn_we     = 1'b0;
        age_we       = 1'b0;
        axis_we      = 1'b0;
        out_load     = 1'b0;
        out_status   = ST_OK;
        out_slot     = '0;
        out_data     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;

        if (clr_reg)
        begin
            ord_we = 1'b1;
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == SLOT_W'(CAPACITY - 1))
                clr_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    case (mode_t'(in_mode))
                        MODE_TICK:
                        begin
                            idx_next = cnt_reg;
                            state_next = S_TK_NEXT;
                        end
                        MODE_SPAWN:
                        begin
                            ord_raddr = cnt_reg[SLOT_W-1:0];
                            state_next = (cnt_reg == CNT_W'(CAPACITY)) ? S_DONE : S_RD_ORDER;
                        end
                        MODE_KILL:
                        begin
                            cnt_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            ord_raddr = in_idx;
                            state_next = (CNT_W'(in_idx) >= cnt_reg) ? S_DONE : S_RD_ORDER;
                        end
                    endcase
                end
            end
            S_RD_ORDER:
                state_next = (in_reg[1:0] == MODE_SPAWN) ? S_SPAWN_WR : S_READ_DATA;
            S_SPAWN_WR:
            begin
                spawn_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                out_load = 1'b1;
                out_slot = slot_reg;
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_READ_DATA:
                state_next = S_READ_OUT;
            S_READ_OUT:
            begin
                out_load = 1'b1;
                out_slot = slot_reg;
                out_data = 1'b1;
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_TK_NEXT:
            begin
                if (idx_reg == '0)
                    state_next = S_DONE;
                else
                begin
                    idx_next = idx_reg - 1'b1;
                    ord_raddr = idx_next[SLOT_W-1:0];
                    state_next = S_TK_ORDER;
                end
            end
            S_TK_ORDER:
                state_next = S_TK_SLOT;
            S_TK_SLOT:
                state_next = S_TK_AGE;
            S_TK_AGE:
            begin
                if (flag_q[0])
                    state_next = S_TK_NEXT;
                else
                    state_next = S_TK_AXIS;
            end
            S_TK_AXIS:
            begin
                // age decision on the first axis only; later passes just load the multiplier
                if (axis_reg != 2'd0)
                    state_next = S_TK_AXWR;
                else if (age_sum[32:16] != '0)
                begin
                    ord_raddr = SLOT_W'(cnt_reg - 1'b1);
                    state_next = S_TK_KILL_LAST;
                end
                else
                begin
                    age_we = 1'b1;
                    state_next = S_TK_AXWR;
                end
            end
            S_TK_AXWR:
            begin
                axis_we = (axis_reg == 2'd3) ? !flag_q[2] : !flag_q[1];
                axis_next = axis_reg + 1'b1;
                if (axis_reg == 2'd3)
                    state_next = S_TK_NEXT;
                else
                    state_next = S_TK_AXIS;
            end
            S_TK_KILL_LAST:
            begin
                ord_we = 1'b1;
                ord_waddr = idx_reg[SLOT_W-1:0];
                ord_wdata = ord_rdata_reg;
                state_next = S_TK_KILL_WR;
            end
            S_TK_KILL_WR:
            begin
                ord_we = 1'b1;
                ord_waddr = SLOT_W'(cnt_reg - 1'b1);
                ord_wdata = slot_reg;
                cnt_next = cnt_reg - 1'b1;
                state_next = S_TK_NEXT;
            end
            S_DONE:
            begin
                out_load = 1'b1;
                if (in_reg[1:0] == MODE_SPAWN)
                    out_status = ST_FULL;
                else if (in_reg[1:0] == MODE_READ)
                    out_status = ST_OOR;
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Testbench for particle_pool_lifetime_update: scoreboard with pool predictor, stream drivers.
`default_nettype none
module tb_top
    import ppl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        mode_t              mode;
        logic [23:0]        dt;
        logic signed [31:0] px, py, pz, vx, vy, vz, spin_rate;
        logic [23:0]        inv_life;
        logic [3:0]         flags;
        logic [7:0]         idx;
    } pool_cmd_t;

    typedef struct {
        logic [8:0]  count;
        status_t     status;
        logic [7:0]  slot;
        logic [31:0] px, py, pz, rot;
        logic [15:0] age;
        logic [3:0]  flags;
    } pool_resp_t;

    class pool_scoreboard;
        int                 order [CAPACITY];
        int                 live;
        logic signed [31:0] pos [CAPACITY][3];
        logic signed [31:0] vel [CAPACITY][3];
        logic [31:0]        rot [CAPACITY];
        logic signed [31:0] rate [CAPACITY];
        logic [16:0]        age [CAPACITY];
        logic [23:0]        inv [CAPACITY];
        logic [3:0]         flg [CAPACITY];
        pool_resp_t         pending [$];
        int                 errors;

        function new();
            for (int i = 0; i < CAPACITY; i++)
                order[i] = i;
            live = 0;
            errors = 0;
        endfunction

        function longint step(logic signed [31:0] r, logic [23:0] dt);
            longint p;
            p = longint'(r) * longint'({1'b0, dt});
            return p >>> 16;
        endfunction

        function logic signed [31:0] sat(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function void age_all(logic [23:0] dt);
            int     s;
            int     t;
            longint a;
            for (int i = live - 1; i >= 0; i--) begin
                s = order[i];
                if (flg[s][0])
                    continue;
                a = longint'(age[s]) + ((longint'(dt) * longint'(inv[s])) >>> 16);
                if (a >= 65536) begin
                    t = order[i];
                    order[i] = order[live - 1];
                    order[live - 1] = t;
                    live--;
                    continue;
                end
                age[s] = a[16:0];
                if (!flg[s][1])
                    for (int k = 0; k < 3; k++)
                        pos[s][k] = sat(longint'(pos[s][k]) + step(vel[s][k], dt));
                if (!flg[s][2])
                    rot[s] = rot[s] + 32'(step(rate[s], dt));
                flg[s][3] = 1'b0;
            end
        endfunction

        function void note(pool_cmd_t c);
            pool_resp_t r;
            int         s;
            r.count = '0;
            r.status = ST_OK;
            r.slot = '0;
            r.px = '0;
            r.py = '0;
            r.pz = '0;
            r.rot = '0;
            r.age = '0;
            r.flags = '0;
            case (c.mode)
                MODE_TICK: age_all(c.dt);
                MODE_SPAWN: begin
                    if (live >= CAPACITY)
                        r.status = ST_FULL;
                    else begin
                        s = order[live];
                        live++;
                        pos[s] = '{c.px, c.py, c.pz};
                        vel[s] = '{c.vx, c.vy, c.vz};
                        rate[s] = c.spin_rate;
                        inv[s] = c.inv_life;
                        flg[s] = c.flags;
                        rot[s] = '0;
                        age[s] = '0;
                        r.slot = s[7:0];
                    end
                end
                MODE_KILL: live = 0;
                default: begin
                    if (int'(c.idx) >= live)
                        r.status = ST_OOR;
                    else begin
                        s = order[c.idx];
                        r.slot = s[7:0];
                        r.px = pos[s][0];
                        r.py = pos[s][1];
                        r.pz = pos[s][2];
                        r.rot = rot[s];
                        r.age = age[s][15:0];
                        r.flags = flg[s];
                    end
                end
            endcase
            r.count = live[8:0];
            pending.push_back(r);
        endfunction

        function void check(logic [167:0] d);
            pool_resp_t e;
            if (pending.size() == 0) begin
                $error("unexpected result %0h", d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[8:0] != e.count) begin
                $error("live_count exp %0d act %0d", e.count, d[8:0]); errors++;
            end
            if (d[10:9] != e.status) begin
                $error("status exp %0d act %0d", e.status, d[10:9]); errors++;
            end
            if (d[18:11] != e.slot) begin
                $error("slot exp %0d act %0d", e.slot, d[18:11]); errors++;
            end
            if (d[50:19] != e.px) begin
                $error("out_pos_x exp %0h act %0h", e.px, d[50:19]); errors++;
            end
            if (d[82:51] != e.py) begin
                $error("out_pos_y exp %0h act %0h", e.py, d[82:51]); errors++;
            end
            if (d[114:83] != e.pz) begin
                $error("out_pos_z exp %0h act %0h", e.pz, d[114:83]); errors++;
            end
            if (d[146:115] != e.rot) begin
                $error("out_rotation exp %0h act %0h", e.rot, d[146:115]); errors++;
            end
            if (d[162:147] != e.age) begin
                $error("out_age exp %0h act %0h", e.age, d[162:147]); errors++;
            end
            if (d[166:163] != e.flags) begin
                $error("out_flags exp %0h act %0h", e.flags, d[166:163]); errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;

    pool_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             quiet_cycles = 0;

    particle_pool_lifetime_update DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (m_tvalid && m_tready)
            sb.check(m_tdata);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function pool_cmd_t rand_cmd(mode_t m);
        pool_cmd_t c;
        c.mode = m;
        c.dt = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(65535));
        c.px = $urandom;
        c.py = $urandom;
        c.pz = $urandom;
        c.vx = $urandom;
        c.vy = $urandom;
        c.vz = $urandom;
        c.spin_rate = $urandom;
        c.inv_life = ($urandom_range(5) == 0) ? 24'($urandom) : 24'($urandom_range(4095));
        c.flags = 4'($urandom);
        c.idx = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(sb.live));
        return c;
    endfunction

    task automatic send(pool_cmd_t c);
        s_tvalid <= 1'b1;
        s_tdata <= {2'd0, c.idx, c.flags, c.inv_life, c.spin_rate, c.vz, c.vy, c.vx,
                    c.pz, c.py, c.px, c.dt, c.mode};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note(c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_items(int n);
        int   r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40)
                send(rand_cmd(MODE_SPAWN));
            else if (r < 65)
                send(rand_cmd(MODE_TICK));
            else if (r < 95)
                send(rand_cmd(MODE_READ));
            else
                send(rand_cmd(MODE_KILL));
        end
    endtask

    initial
    begin
        pool_cmd_t c;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, saturation, freezes, out-of-range, empty tick
        c = rand_cmd(MODE_TICK);
        c.dt = 24'hffffff;
        send(c);
        c = rand_cmd(MODE_SPAWN);
        c.px = 32'sh7fffffff; c.py = 32'sh80000000; c.pz = 32'sh7ffffff0;
        c.vx = 32'sh7fffffff; c.vy = 32'sh80000000; c.vz = 32'sh7fffffff;
        c.spin_rate = 32'sh7fffffff; c.inv_life = 24'd0; c.flags = 4'b1000;
        send(c);
        for (int f = 0; f < 16; f += 3) begin
            c = rand_cmd(MODE_SPAWN);
            c.flags = f[3:0];
            c.inv_life = 24'd16;
            send(c);
        end
        c = rand_cmd(MODE_SPAWN);
        c.inv_life = 24'hffffff; c.flags = 4'b0000;
        c.spin_rate = 32'sh80000000;
        send(c);
        for (int i = 0; i < 3; i++) begin
            c = rand_cmd(MODE_TICK);
            c.dt = (i == 0) ? 24'hffffff : 24'h010000;
            send(c);
        end
        for (int i = 0; i < 4; i++) begin
            c = rand_cmd(MODE_READ);
            c.idx = i[7:0];
            send(c);
        end
        c = rand_cmd(MODE_READ);
        c.idx = 8'hff;
        send(c);
        send(rand_cmd(MODE_KILL));
        send(rand_cmd(MODE_TICK));
        c = rand_cmd(MODE_READ);
        c.idx = 8'd0;
        send(c);

        // fill the pool to capacity and overflow it
        drain();
        for (int i = 0; i < CAPACITY + 2; i++)
            send(rand_cmd(MODE_SPAWN));
        c = rand_cmd(MODE_READ);
        c.idx = 8'hff;
        send(c);
        c = rand_cmd(MODE_TICK);
        c.dt = 24'h000100;
        send(c);
        for (int i = 0; i < 6; i++)
            send(rand_cmd(MODE_READ));
        send(rand_cmd(MODE_KILL));

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 32) : 0;
            recv_stall_pct = (ph == 2) ? 84 : ((ph == 3) ? 32 : 0);
            random_items(390);
        end

        drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/ppl_pkg.sv
hw/rtl/ppl_step_unit.sv
hw/rtl/particle_pool_lifetime_update.sv
test/tb_top.sv
